FILE: hdl/track_machine_motion_classifier_top_assert.svh
// ----------------------------------------------------------------------------
// track machine motion classifier assertion macros
// concurrent checks sampled on i_clk, off while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef TRACK_MACHINE_MOTION_CLASSIFIER_TOP_ASSERT_SVH
`define TRACK_MACHINE_MOTION_CLASSIFIER_TOP_ASSERT_SVH

// same-cycle implication
`define TMMC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define TMMC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/tmmc_pkg.sv
// ----------------------------------------------------------------------------
// tmmc_pkg
// shared constants of the track machine motion classifier
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tmmc_pkg;

    localparam int SPEED_BITS_DEF = 16;
    localparam int LIMIT_W        = 15;
    localparam int CODE_W         = 4;
    localparam int CFG_IDX_W      = 3;
    localparam int FLAG_W         = 4;
    localparam int OUT_FLAG_W     = 2;
    localparam int OUT_DATA_W     = 8;

    // motion class codes
    localparam logic [CODE_W-1:0] CODE_IDLE     = 4'd0;
    localparam logic [CODE_W-1:0] CODE_CUT      = 4'd1;
    localparam logic [CODE_W-1:0] CODE_FWD      = 4'd2;
    localparam logic [CODE_W-1:0] CODE_REV      = 4'd3;
    localparam logic [CODE_W-1:0] CODE_TURN     = 4'd4;
    localparam logic [CODE_W-1:0] CODE_NODISP   = 4'd5;
    localparam logic [CODE_W-1:0] CODE_CONFLICT = 4'd6;
    localparam logic [CODE_W-1:0] CODE_RELOC    = 4'd7;
    localparam logic [CODE_W-1:0] CODE_UNKNOWN  = 4'd8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_STATIC = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_MOVE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_STATIC = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LIDAR_MOVE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_DELTA   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_VIB_STATIC   = 3'd5;

    // register reset values, Q7.8
    localparam logic [LIMIT_W-1:0] RST_TRACK_STATIC = 15'd26;
    localparam logic [LIMIT_W-1:0] RST_TRACK_MOVE   = 15'd51;
    localparam logic [LIMIT_W-1:0] RST_LIDAR_STATIC = 15'd13;
    localparam logic [LIMIT_W-1:0] RST_LIDAR_MOVE   = 15'd26;
    localparam logic [LIMIT_W-1:0] RST_TURN_DELTA   = 15'd26;
    localparam logic [LIMIT_W-1:0] RST_VIB_STATIC   = 15'd64;

    // stage 2 decisions
    typedef struct packed {
        logic bad_order;
        logic fault;
        logic reloc;
        logic cutting;
        logic still_track;
        logic still_lidar;
        logic moving_lidar;
        logic calm_imu;
        logic turn;
        logic fwd;
        logic rev;
    } t_decision;

endpackage

FILE: hdl/track_machine_motion_classifier_top.sv
// ----------------------------------------------------------------------------
// track_machine_motion_classifier_top
// path: an accepted sample passes the stage 1, stage 2 and stage 3 registers, and
//   the result is driven from the stage 3 register
// throughput: one sample per cycle, three register stages with per-stage
//   valid bits and a stall that backs up stage by stage
// reset: synchronous active low, clears valid bits and loads default limits
// classifies one sample of track, lidar and imu data into a motion class
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "track_machine_motion_classifier_top_assert.svh"

module track_machine_motion_classifier_top #(
    parameter int SPEED_BITS = tmmc_pkg::SPEED_BITS_DEF,
    localparam int IN_DATA_W = ((4 * SPEED_BITS + 7) / 8) * 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_wr_en,
    input  logic [tmmc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [tmmc_pkg::LIMIT_W-1:0]      i_cfg_wdata,
    // sample input
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // left_speed, right_speed, lidar_speed_in, vibration_level, zero pad
    input  logic [IN_DATA_W-1:0]              s_axis_tdata,
    // signal_fault, relocalizing_flag, cutter_running, imu_healthy
    input  logic [tmmc_pkg::FLAG_W-1:0]       s_axis_tuser,
    // result output
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // state_code, zero pad
    output logic [tmmc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
    // map_write_ok, pose_frozen
    output logic [tmmc_pkg::OUT_FLAG_W-1:0]   m_axis_tuser
);

    import tmmc_pkg::*;

    localparam int CW = (SPEED_BITS + 2 > 17) ? SPEED_BITS + 2 : 17;

    // configuration registers
    logic [LIMIT_W-1:0] r_track_static;
    logic [LIMIT_W-1:0] r_track_move;
    logic [LIMIT_W-1:0] r_lidar_static;
    logic [LIMIT_W-1:0] r_lidar_move;
    logic [LIMIT_W-1:0] r_turn_delta;
    logic [LIMIT_W-1:0] r_vib_static;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_static <= RST_TRACK_STATIC;
            r_track_move   <= RST_TRACK_MOVE;
            r_lidar_static <= RST_LIDAR_STATIC;
            r_lidar_move   <= RST_LIDAR_MOVE;
            r_turn_delta   <= RST_TURN_DELTA;
            r_vib_static   <= RST_VIB_STATIC;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_TRACK_STATIC: r_track_static <= i_cfg_wdata;
                REG_TRACK_MOVE:   r_track_move   <= i_cfg_wdata;
                REG_LIDAR_STATIC: r_lidar_static <= i_cfg_wdata;
                REG_LIDAR_MOVE:   r_lidar_move   <= i_cfg_wdata;
                REG_TURN_DELTA:   r_turn_delta   <= i_cfg_wdata;
                REG_VIB_STATIC:   r_vib_static   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // limits widened to the compare width
    logic signed [CW-1:0] lim_track_static, lim_track_move, lim_lidar_static;
    logic signed [CW-1:0] lim_lidar_move, lim_turn_delta, lim_vib_static;
    logic signed [CW-1:0] neg_track_move, neg_turn_delta;

    assign lim_track_static = $signed({{(CW-LIMIT_W){1'b0}}, r_track_static});
    assign lim_track_move   = $signed({{(CW-LIMIT_W){1'b0}}, r_track_move});
    assign lim_lidar_static = $signed({{(CW-LIMIT_W){1'b0}}, r_lidar_static});
    assign lim_lidar_move   = $signed({{(CW-LIMIT_W){1'b0}}, r_lidar_move});
    assign lim_turn_delta   = $signed({{(CW-LIMIT_W){1'b0}}, r_turn_delta});
    assign lim_vib_static   = $signed({{(CW-LIMIT_W){1'b0}}, r_vib_static});
    assign neg_track_move   = -lim_track_move;
    assign neg_turn_delta   = -lim_turn_delta;

    // stage handshake
    logic r1_valid, r2_valid, r3_valid;
    logic ready1, ready2, ready3;

    assign ready3        = !r3_valid || m_axis_tready;
    assign ready2        = !r2_valid || ready3;
    assign ready1        = !r1_valid || ready2;
    assign s_axis_tready = ready1;

    // stage 1: widen, magnitudes, difference
    logic [SPEED_BITS-1:0] in_left, in_right, in_lidar, in_vib;
    logic signed [CW-1:0]  x_left, x_right, x_lidar, x_vib;

    assign in_left  = s_axis_tdata[SPEED_BITS-1:0];
    assign in_right = s_axis_tdata[2*SPEED_BITS-1:SPEED_BITS];
    assign in_lidar = s_axis_tdata[3*SPEED_BITS-1:2*SPEED_BITS];
    assign in_vib   = s_axis_tdata[4*SPEED_BITS-1:3*SPEED_BITS];

    assign x_left  = $signed({{(CW-SPEED_BITS){in_left[SPEED_BITS-1]}}, in_left});
    assign x_right = $signed({{(CW-SPEED_BITS){in_right[SPEED_BITS-1]}}, in_right});
    assign x_lidar = $signed({{(CW-SPEED_BITS){in_lidar[SPEED_BITS-1]}}, in_lidar});
    assign x_vib   = $signed({{(CW-SPEED_BITS){in_vib[SPEED_BITS-1]}}, in_vib});

    logic signed [CW-1:0] r1_left, r1_right, r1_mag_left, r1_mag_right;
    logic signed [CW-1:0] r1_mag_lidar, r1_diff, r1_vib;
    logic                 r1_left_pos, r1_left_neg, r1_right_pos, r1_right_neg;
    logic                 r1_fault, r1_reloc, r1_cutting, r1_imu_ok, r1_bad_order;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ready1) begin
            r1_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready1) begin
            r1_left      <= x_left;
            r1_right     <= x_right;
            r1_mag_left  <= x_left[CW-1] ? -x_left : x_left;
            r1_mag_right <= x_right[CW-1] ? -x_right : x_right;
            r1_mag_lidar <= x_lidar[CW-1] ? -x_lidar : x_lidar;
            r1_diff      <= x_left - x_right;
            r1_vib       <= x_vib;
            r1_left_pos  <= !in_left[SPEED_BITS-1] && (in_left != '0);
            r1_left_neg  <= in_left[SPEED_BITS-1];
            r1_right_pos <= !in_right[SPEED_BITS-1] && (in_right != '0);
            r1_right_neg <= in_right[SPEED_BITS-1];
            r1_fault     <= s_axis_tuser[0];
            r1_reloc     <= s_axis_tuser[1];
            r1_cutting   <= s_axis_tuser[2];
            r1_imu_ok    <= s_axis_tuser[3];
            r1_bad_order <= (r_track_move < r_track_static) ||
                            (r_lidar_move < r_lidar_static);
        end
    end

    // stage 2: threshold compares
    t_decision n2_dec, r2_dec;

    always_comb begin
        n2_dec.bad_order    = r1_bad_order;
        n2_dec.fault        = r1_fault;
        n2_dec.reloc        = r1_reloc;
        n2_dec.cutting      = r1_cutting;
        n2_dec.still_track  = (r1_mag_left <= lim_track_static) &&
                              (r1_mag_right <= lim_track_static);
        n2_dec.still_lidar  = r1_mag_lidar <= lim_lidar_static;
        n2_dec.moving_lidar = r1_mag_lidar >= lim_lidar_move;
        n2_dec.calm_imu     = r1_imu_ok && (r1_vib <= lim_vib_static);
        n2_dec.turn         = (r1_diff >= lim_turn_delta) || (r1_diff <= neg_turn_delta) ||
                              (r1_left_neg && r1_right_pos) || (r1_left_pos && r1_right_neg);
        n2_dec.fwd          = (r1_left >= lim_track_move) && (r1_right >= lim_track_move);
        n2_dec.rev          = (r1_left <= neg_track_move) && (r1_right <= neg_track_move);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r2_dec <= n2_dec;
        end
    end

    // stage 3: priority chain
    logic [CODE_W-1:0] n3_code, r3_code;

    always_comb begin
        if (r2_dec.fault || r2_dec.bad_order) begin
            n3_code = CODE_CONFLICT;
        end else if (r2_dec.reloc) begin
            n3_code = CODE_RELOC;
        end else if (r2_dec.still_track && !r2_dec.still_lidar) begin
            n3_code = CODE_CONFLICT;
        end else if (r2_dec.still_track && r2_dec.cutting) begin
            n3_code = CODE_CUT;
        end else if (r2_dec.still_track && r2_dec.calm_imu) begin
            n3_code = CODE_IDLE;
        end else if (r2_dec.turn) begin
            n3_code = r2_dec.moving_lidar ? CODE_TURN : CODE_NODISP;
        end else if (r2_dec.fwd) begin
            n3_code = r2_dec.moving_lidar ? CODE_FWD : CODE_NODISP;
        end else if (r2_dec.rev) begin
            n3_code = r2_dec.moving_lidar ? CODE_REV : CODE_NODISP;
        end else begin
            n3_code = CODE_UNKNOWN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (ready3) begin
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r3_code <= n3_code;
        end
    end

    logic map_write_ok, pose_frozen;

    always_comb begin
        case (r3_code)
            CODE_IDLE, CODE_FWD: map_write_ok = 1'b1;
            default:             map_write_ok = 1'b0;
        endcase
        case (r3_code)
            CODE_IDLE, CODE_CUT, CODE_NODISP, CODE_CONFLICT, CODE_RELOC:
                pose_frozen = 1'b1;
            default:
                pose_frozen = 1'b0;
        endcase
    end

    assign m_axis_tvalid = r3_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-CODE_W){1'b0}}, r3_code};
    assign m_axis_tuser  = {pose_frozen, map_write_ok};

    `TMMC_ASSERT_NEXT(a_in_lands_s1, s_axis_tvalid && s_axis_tready, r1_valid,
        "accepted sample did not reach stage 1")
    `TMMC_ASSERT_NEXT(a_fault_conflict, r2_valid && ready3 && (r2_dec.fault || r2_dec.bad_order),
        r3_code == CODE_CONFLICT, "fault or bad ordering did not give conflict")
    `TMMC_ASSERT_NOW(a_code_range, m_axis_tvalid,
        r3_code <= CODE_UNKNOWN, "state code out of range")
    `TMMC_ASSERT_NOW(a_flags_exclusive, m_axis_tvalid && map_write_ok,
        !pose_frozen || r3_code == CODE_IDLE, "map write allowed while pose frozen")
    `TMMC_ASSERT_NEXT(a_stall_holds, r3_valid && !m_axis_tready,
        r3_valid && $stable(r3_code), "stalled result changed")

endmodule

FILE: tb/track_machine_motion_classifier_top_tb.sv
// ----------------------------------------------------------------------------
// track_machine_motion_classifier_top_tb
// drives sensor samples into the classifier and checks every class code and
// both derived flags against a cycle-free predictor; runs directed corner
// samples, then random samples shaped around the limits under several limit
// settings, with random gaps and stalls on both stream sides
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module track_machine_motion_classifier_top_tb;

    import tmmc_pkg::*;

    localparam int                   SPD_W       = SPEED_BITS_DEF;
    localparam int                   RAND_ITEMS  = 150;
    localparam int                   NUM_PHASES  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [SPD_W-1:0] left;
        logic [SPD_W-1:0] right;
        logic [SPD_W-1:0] lidar;
        logic [SPD_W-1:0] vib;
        logic             fault;
        logic             reloc;
        logic             cut;
        logic             imu;
    } t_sample;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic              map_ok;
        logic              frozen;
    } t_motion;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [LIMIT_W-1:0]    i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // left_speed, right_speed, lidar_speed_in, vibration_level
    logic [4*SPD_W-1:0]    s_axis_tdata  = '0;
    // signal_fault, relocalizing_flag, cutter_running, imu_healthy
    logic [FLAG_W-1:0]     s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // state_code, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // map_write_ok, pose_frozen
    logic [OUT_FLAG_W-1:0] m_axis_tuser;

    t_sample sample_q[$];
    t_motion motion_q[$];
    t_sample cur_sample;
    int      lim [0:5];
    int      tx_idle_pct = 32;
    int      rx_idle_pct = 47;
    int      n_sent      = 0;
    int      n_seen      = 0;
    int      n_err       = 0;
    int      code_hits [0:15];

    track_machine_motion_classifier_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 i_clk = ~i_clk;

    function automatic int mag(int v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic [SPD_W-1:0] sat16(int v);
        if (v > 32767) return 16'h7FFF;
        if (v < -32768) return 16'h8000;
        return v[SPD_W-1:0];
    endfunction

    function automatic int jitter(int v, int span);
        return v + int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_motion classify_motion(t_sample s);
        int      l, r, ld, vb;
        logic    trk_st, lid_st, lid_mv, imu_st;
        t_motion m;
        l      = $signed(s.left);
        r      = $signed(s.right);
        ld     = $signed(s.lidar);
        vb     = $signed(s.vib);
        trk_st = mag(l) <= lim[REG_TRACK_STATIC] && mag(r) <= lim[REG_TRACK_STATIC];
        lid_st = mag(ld) <= lim[REG_LIDAR_STATIC];
        lid_mv = mag(ld) >= lim[REG_LIDAR_MOVE];
        imu_st = s.imu && vb <= lim[REG_VIB_STATIC];
        if (s.fault || lim[REG_TRACK_MOVE] < lim[REG_TRACK_STATIC] ||
                lim[REG_LIDAR_MOVE] < lim[REG_LIDAR_STATIC]) begin
            m.code = CODE_CONFLICT;
        end else if (s.reloc) begin
            m.code = CODE_RELOC;
        end else if (trk_st && !lid_st) begin
            m.code = CODE_CONFLICT;
        end else if (trk_st && s.cut) begin
            m.code = CODE_CUT;
        end else if (trk_st && imu_st) begin
            m.code = CODE_IDLE;
        end else if (mag(l - r) >= lim[REG_TURN_DELTA] || (l < 0 && r > 0) ||
                (l > 0 && r < 0)) begin
            m.code = lid_mv ? CODE_TURN : CODE_NODISP;
        end else if (l >= lim[REG_TRACK_MOVE] && r >= lim[REG_TRACK_MOVE]) begin
            m.code = lid_mv ? CODE_FWD : CODE_NODISP;
        end else if (l <= -lim[REG_TRACK_MOVE] && r <= -lim[REG_TRACK_MOVE]) begin
            m.code = lid_mv ? CODE_REV : CODE_NODISP;
        end else begin
            m.code = CODE_UNKNOWN;
        end
        m.map_ok = (m.code == CODE_IDLE || m.code == CODE_FWD);
        m.frozen = (m.code == CODE_IDLE || m.code == CODE_CUT || m.code == CODE_NODISP ||
                    m.code == CODE_CONFLICT || m.code == CODE_RELOC);
        return m;
    endfunction

    // samples clustered around the current limits, plus noise and corners
    function automatic t_sample random_sample();
        int      base, d, sgn;
        t_sample s;
        s.fault = ($urandom_range(0, 9) == 0);
        s.reloc = ($urandom_range(0, 9) == 0);
        s.cut   = 1'($urandom_range(0, 1));
        s.imu   = ($urandom_range(0, 4) != 0);
        sgn     = $urandom_range(0, 1) ? 1 : -1;
        case ($urandom_range(0, 5))
            0: begin
                s.left  = sat16(jitter(0, lim[REG_TRACK_STATIC] + 1));
                s.right = sat16(jitter(0, lim[REG_TRACK_STATIC] + 1));
                s.lidar = sat16(jitter(0, lim[REG_LIDAR_STATIC] + 1));
            end
            1, 2: begin
                base    = lim[REG_TRACK_MOVE] + int'($urandom_range(0, 40)) - 3;
                s.left  = sat16(sgn * base);
                s.right = sat16(sgn * jitter(base, 2));
                s.lidar = sat16(sgn * jitter(lim[REG_LIDAR_MOVE], 2));
            end
            3: begin
                d       = jitter(lim[REG_TURN_DELTA], 2);
                base    = jitter(0, 64);
                s.left  = sat16(base);
                s.right = sat16(base - sgn * d);
                s.lidar = sat16(sgn * jitter(lim[REG_LIDAR_MOVE], 3));
            end
            4: begin
                s.left  = SPD_W'($urandom);
                s.right = SPD_W'($urandom);
                s.lidar = SPD_W'($urandom);
            end
            default: begin
                s.left  = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
                s.right = $urandom_range(0, 1) ? 16'h8000 : sat16(jitter(0, 1));
                s.lidar = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
            end
        endcase
        case ($urandom_range(0, 3))
            0:       s.vib = SPD_W'($urandom);
            3:       s.vib = sat16(-int'($urandom_range(1, 40000)));
            default: s.vib = sat16(jitter(lim[REG_VIB_STATIC], 2));
        endcase
        return s;
    endfunction

    task automatic push_sample(t_sample s);
        sample_q.push_back(s);
        n_sent++;
    endtask

    task automatic write_limit(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val[LIMIT_W-1:0];
        if (idx <= REG_VIB_STATIC) lim[idx] = val & 32'h7FFF;
    endtask

    task automatic load_limits(int ts, int tm, int ls, int lm, int td, int vs);
        write_limit(REG_TRACK_STATIC, ts);
        write_limit(REG_TRACK_MOVE, tm);
        write_limit(REG_LIDAR_STATIC, ls);
        write_limit(REG_LIDAR_MOVE, lm);
        write_limit(REG_TURN_DELTA, td);
        write_limit(REG_VIB_STATIC, vs);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic wait_drained();
        while (n_seen < n_sent) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    // sample driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) motion_q.push_back(classify_motion(cur_sample));
            if (!s_axis_tvalid || s_axis_tready) begin
                if (sample_q.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                    cur_sample = sample_q.pop_front();
                    s_axis_tdata  <= {cur_sample.vib, cur_sample.lidar,
                                      cur_sample.right, cur_sample.left};
                    s_axis_tuser  <= {cur_sample.imu, cur_sample.cut,
                                      cur_sample.reloc, cur_sample.fault};
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_motion got, want;
        m_axis_tready <= i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.code   = m_axis_tdata[CODE_W-1:0];
            got.map_ok = m_axis_tuser[0];
            got.frozen = m_axis_tuser[1];
            n_seen++;
            code_hits[got.code]++;
            if (motion_q.size() == 0) begin
                n_err++;
                $display("%0t: result transfer with nothing expected, code %0d", $time,
                         got.code);
            end else begin
                want = motion_q.pop_front();
                if (got.code !== want.code) begin
                    n_err++;
                    $display("%0t: state_code expected %0d got %0d", $time, want.code,
                             got.code);
                end
                if (got.map_ok !== want.map_ok) begin
                    n_err++;
                    $display("%0t: map_write_ok expected %0b got %0b", $time, want.map_ok,
                             got.map_ok);
                end
                if (got.frozen !== want.frozen) begin
                    n_err++;
                    $display("%0t: pose_frozen expected %0b got %0b", $time, want.frozen,
                             got.frozen);
                end
            end
        end
    end

    initial begin
        int a, b;
        lim[REG_TRACK_STATIC] = RST_TRACK_STATIC;
        lim[REG_TRACK_MOVE]   = RST_TRACK_MOVE;
        lim[REG_LIDAR_STATIC] = RST_LIDAR_STATIC;
        lim[REG_LIDAR_MOVE]   = RST_LIDAR_MOVE;
        lim[REG_TURN_DELTA]   = RST_TURN_DELTA;
        lim[REG_VIB_STATIC]   = RST_VIB_STATIC;
        foreach (code_hits[i]) code_hits[i] = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners under reset limits
        push_sample('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b1, 1'b0, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd100, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        push_sample('{16'd0, 16'd0, 16'd0, 16'h8000, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd0, 16'd0, 16'd0, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd51, 16'd51, 16'd26, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd51, 16'd51, 16'd25, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{-16'sd51, -16'sd51, -16'sd26, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd100, 16'd50, 16'd30, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd1, -16'sd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        push_sample('{16'd0, -16'sd1, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b0});
        push_sample('{16'h7FFF, 16'h8000, 16'h8000, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'h8000, 16'h8000, 16'h8000, 16'd0, 1'b0, 1'b0, 1'b1, 1'b1});
        push_sample('{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd26, -16'sd26, 16'd13, 16'd64, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd26, 16'd26, -16'sd13, 16'd64, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'd27, 16'd27, 16'd0, 16'd0, 1'b0, 1'b0, 1'b0, 1'b1});
        push_sample('{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1, 1'b1});
        wait_drained();

        for (int ph = 1; ph <= NUM_PHASES; ph++) begin
            if (ph == 4) begin
                tx_idle_pct = 47;
                rx_idle_pct = 32;
            end else if (ph == 7) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            a = $urandom_range(0, 200);
            b = $urandom_range(0, 100);
            case (ph)
                1: ;
                3: begin
                    // spare indexes must leave every limit untouched
                    write_limit(REG_SPARE_LO, $urandom_range(0, 32767));
                    write_limit(REG_SPARE_HI, $urandom_range(0, 32767));
                    load_limits(0, 0, 0, 0, 0, 0);
                end
                4: load_limits(32767, 32767, 32767, 32767, 32767, 32767);
                5: load_limits(100, 50, 13, 26, 26, 64);
                6: load_limits(26, 51, 60, 20, 26, 64);
                7: load_limits($urandom_range(0, 32767), $urandom_range(0, 32767),
                               $urandom_range(0, 32767), $urandom_range(0, 32767),
                               $urandom_range(0, 32767), $urandom_range(0, 32767));
                default: load_limits(a, a + $urandom_range(0, 200), b,
                                     b + $urandom_range(0, 100), $urandom_range(0, 300),
                                     $urandom_range(0, 500));
            endcase
            repeat (RAND_ITEMS) push_sample(random_sample());
            wait_drained();
        end

        repeat (8) @(posedge i_clk);
        if (motion_q.size() != 0) begin
            n_err++;
            $display("%0t: %0d expected results never arrived", $time, motion_q.size());
        end
        $display("classified %0d samples over %0d limit settings", n_seen, NUM_PHASES + 1);
        $display("classes idle %0d cut %0d fwd %0d rev %0d turn %0d",
                 code_hits[CODE_IDLE], code_hits[CODE_CUT], code_hits[CODE_FWD],
                 code_hits[CODE_REV], code_hits[CODE_TURN],
                 " nodisp %0d conflict %0d reloc %0d unknown %0d",
                 code_hits[CODE_NODISP], code_hits[CODE_CONFLICT],
                 code_hits[CODE_RELOC], code_hits[CODE_UNKNOWN]);
        if (n_err == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("%0t: timeout with %0d of %0d results seen", $time, n_seen, n_sent);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
